[rtl/core/kwm_pkg.sv]
// ----------------------------------------------------------------------------
// kwm_pkg: shared types for the k-way merge heap
// Item payloads, heap entry, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package kwm_pkg;

  typedef struct packed {
    logic [3:0]         lane;
    logic signed [31:0] head_value;
    logic               has_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] min_value;
    logic [3:0]         src_lane;
    logic               done_res;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [3:0]         lane;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef enum logic [11:0] {
    ST_IDLE     = 12'b0000_0000_0001,
    ST_START    = 12'b0000_0000_0010,
    ST_INS_CHK  = 12'b0000_0000_0100,
    ST_INS_CMP  = 12'b0000_0000_1000,
    ST_DECIDE   = 12'b0000_0001_0000,
    ST_POP_TOP  = 12'b0000_0010_0000,
    ST_POP_LAST = 12'b0000_0100_0000,
    ST_DN_CHK   = 12'b0000_1000_0000,
    ST_DN_L     = 12'b0001_0000_0000,
    ST_DN_R     = 12'b0010_0000_0000,
    ST_DN_CMP   = 12'b0100_0000_0000,
    ST_EMIT     = 12'b1000_0000_0000
  } state_t;

  typedef struct packed {
    logic accept;
    logic ins_start;
    logic ins_rd;
    logic ins_move;
    logic ins_place;
    logic prime;
    logic res_done;
    logic pop_rd;
    logic pop_top;
    logic pop_last;
    logic dn_rd_l;
    logic dn_cap_l;
    logic dn_cap_r;
    logic dn_move;
    logic dn_place;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic ins_ok;
    logic pos_zero;
    logic cur_lt_rd;
    logic prime_pend;
    logic cnt_zero;
    logic cnt_one;
    logic left_out;
    logic right_in;
    logic best_cur;
    logic out_free;
  } sts_t;

  // true when entry a orders before entry b: by value, then by lower lane
  function automatic logic entry_before(entry_t a, entry_t b);
    logic res;
    if (a.value != b.value) begin
      res = a.value < b.value;
    end else begin
      res = a.lane < b.lane;
    end
    return res;
  endfunction

endpackage

[rtl/core/kwm_ram.sv]
// ----------------------------------------------------------------------------
// kwm_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module kwm_ram #(
  parameter int unsigned WIDTH = 36,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/kwm_ctrl.sv]
// ----------------------------------------------------------------------------
// kwm_ctrl: sequencer for the merge heap
// Steps each beat through insert sift-up, then, after priming, pop and sift-down, then emits.
// ----------------------------------------------------------------------------
module kwm_ctrl
  import kwm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  sts_t sts,
  output logic in_ready,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  // decode state and status into commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_START;
        end
      end
      ST_START: begin
        if (sts.ins_ok) begin
          cmd.ins_start = 1'b1;
          state_nxt     = ST_INS_CHK;
        end else begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_INS_CHK: begin
        if (sts.pos_zero) begin
          cmd.ins_place = 1'b1;
          state_nxt     = ST_DECIDE;
        end else begin
          cmd.ins_rd = 1'b1;
          state_nxt  = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        if (sts.cur_lt_rd) begin
          cmd.ins_move = 1'b1;
          state_nxt    = ST_INS_CHK;
        end else begin
          cmd.ins_place = 1'b1;
          state_nxt     = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts.prime_pend) begin
          cmd.prime = 1'b1;
          state_nxt = ST_IDLE;
        end else if (sts.cnt_zero) begin
          cmd.res_done = 1'b1;
          state_nxt    = ST_EMIT;
        end else begin
          cmd.pop_rd = 1'b1;
          state_nxt  = ST_POP_TOP;
        end
      end
      ST_POP_TOP: begin
        cmd.pop_top = 1'b1;
        state_nxt   = sts.cnt_one ? ST_EMIT : ST_POP_LAST;
      end
      ST_POP_LAST: begin
        cmd.pop_last = 1'b1;
        state_nxt    = ST_DN_CHK;
      end
      ST_DN_CHK: begin
        if (sts.left_out) begin
          cmd.dn_place = 1'b1;
          state_nxt    = ST_EMIT;
        end else begin
          cmd.dn_rd_l = 1'b1;
          state_nxt   = ST_DN_L;
        end
      end
      ST_DN_L: begin
        cmd.dn_cap_l = 1'b1;
        state_nxt    = sts.right_in ? ST_DN_R : ST_DN_CMP;
      end
      ST_DN_R: begin
        cmd.dn_cap_r = 1'b1;
        state_nxt    = ST_DN_CMP;
      end
      ST_DN_CMP: begin
        if (sts.best_cur) begin
          cmd.dn_place = 1'b1;
          state_nxt    = ST_EMIT;
        end else begin
          cmd.dn_move = 1'b1;
          state_nxt   = ST_DN_CHK;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/kwm_dp.sv]
// ----------------------------------------------------------------------------
// kwm_dp: heap datapath
// Heap RAM, fill and priming counters, sift registers and output register.
// ----------------------------------------------------------------------------
module kwm_dp
  import kwm_pkg::*;
#(
  parameter int unsigned MAX_STREAMS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      cmd,
  input  in_item_t  in_data,
  input  logic [4:0] num_streams,
  input  logic      out_ready,
  output sts_t      sts,
  output logic      out_valid,
  output out_item_t out_data
);

  localparam int unsigned AW = $clog2(MAX_STREAMS);
  localparam int unsigned CW = $clog2(MAX_STREAMS + 1);
  localparam int unsigned IW = AW + 2;

  in_item_t        item_r;
  entry_t          cur_r, l_r, r_r, res_r;
  logic            res_done_r, rv_r;
  logic [CW-1:0]   count_r, count_m1;
  logic [4:0]      primed_r;
  logic [AW-1:0]   pos_r, parent;
  logic [IW-1:0]   left, right, count_x;
  logic            out_valid_r;
  out_item_t       out_r;

  logic            wr_en;
  logic [AW-1:0]   waddr, raddr;
  entry_t          wdata, rdata;
  logic [ENTRY_W-1:0] rdata_raw;
  logic            l_best, r_best;
  entry_t          best;

  // index arithmetic
  assign count_m1 = count_r - 1'b1;
  assign parent   = AW'(pos_r - 1'b1) >> 1;
  assign left     = {1'b0, pos_r, 1'b1};
  assign right    = left + 1'b1;
  assign count_x  = IW'(count_r);
  assign rdata    = entry_t'(rdata_raw);

  // pick the smallest of current, left and right
  always_comb begin
    l_best = entry_before(l_r, cur_r);
    best   = l_best ? l_r : cur_r;
    r_best = rv_r && entry_before(r_r, best);
    if (r_best) begin
      best = r_r;
    end
  end

  // status to the controller
  always_comb begin
    sts.ins_ok     = item_r.has_value && (count_r < CW'(MAX_STREAMS));
    sts.pos_zero   = (pos_r == '0);
    sts.cur_lt_rd  = entry_before(cur_r, rdata);
    sts.prime_pend = primed_r < num_streams;
    sts.cnt_zero   = (count_r == '0);
    sts.cnt_one    = (count_r == CW'(1));
    sts.left_out   = !(left < count_x);
    sts.right_in   = right < count_x;
    sts.best_cur   = !(l_best || r_best);
    sts.out_free   = !out_valid_r || out_ready;
  end

  // RAM port selection
  always_comb begin
    raddr = '0;
    if (cmd.ins_rd) begin
      raddr = parent;
    end else if (cmd.pop_rd) begin
      raddr = '0;
    end else if (cmd.pop_top) begin
      raddr = count_m1[AW-1:0];
    end else if (cmd.dn_rd_l) begin
      raddr = left[AW-1:0];
    end else if (cmd.dn_cap_l) begin
      raddr = right[AW-1:0];
    end
    wr_en = cmd.ins_move || cmd.ins_place || cmd.dn_move || cmd.dn_place;
    waddr = pos_r;
    if (cmd.ins_move) begin
      wdata = rdata;
    end else if (cmd.dn_move) begin
      wdata = best;
    end else begin
      wdata = cur_r;
    end
  end

  kwm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_STREAMS)
  ) u_ram (
    .clk   (clk),
    .wr_en (wr_en),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_raw)
  );

  // control counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      primed_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.ins_start) begin
        count_r <= count_r + 1'b1;
      end else if (cmd.pop_top) begin
        count_r <= count_m1;
      end
      if (cmd.prime) begin
        primed_r <= primed_r + 1'b1;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload and sift registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_r <= in_data;
    end
    if (cmd.ins_start) begin
      pos_r       <= count_r[AW-1:0];
      cur_r.value <= item_r.head_value;
      cur_r.lane  <= item_r.lane;
    end
    if (cmd.ins_move) begin
      pos_r <= parent;
    end
    if (cmd.res_done) begin
      res_done_r <= 1'b1;
      res_r      <= '0;
    end
    if (cmd.pop_top) begin
      res_done_r <= 1'b0;
      res_r      <= rdata;
    end
    if (cmd.pop_last) begin
      cur_r <= rdata;
      pos_r <= '0;
    end
    if (cmd.dn_cap_l) begin
      l_r  <= rdata;
      rv_r <= right < count_x;
    end
    if (cmd.dn_cap_r) begin
      r_r <= rdata;
    end
    if (cmd.dn_move) begin
      pos_r <= r_best ? right[AW-1:0] : left[AW-1:0];
    end
    if (cmd.emit) begin
      out_r.min_value <= res_r.value;
      out_r.src_lane  <= res_r.lane;
      out_r.done_res  <= res_done_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[rtl/core/k_way_merge_min_heap.sv]
// ----------------------------------------------------------------------------
// k_way_merge_min_heap: k-way merge of sorted streams through a min-heap
// Register decode and the controller/datapath pair.
// ----------------------------------------------------------------------------
// Usage:
//   Write num_streams over the cfg_ port (address 0) while idle. Then send
//   num_streams in_ beats, one head per stream, to fill the heap; these give
//   no result. Every later in_ beat refills the lane named in the previous
//   result (has_value = 0 when that stream is exhausted) and yields one out_
//   beat: the smallest head and its lane, or done_res once the heap is empty.
// Sequence:
//   One beat is in flight at a time: an accept step, a start step, an insert
//   that reads and compares the parent per level climbed and places the entry,
//   a decide step, a pop that reads the top and, when entries remain, the last
//   entry and sifts it down through its children, and an emit step, in turn
//   through the single read port of the heap RAM. A priming beat ends after
//   the decide step; a done result skips the pop.
// Reset:
//   rst_n clears the heap fill count, the priming count and num_streams = 1.
// Stall:
//   A result waits in the output register; the next beat is accepted and
//   processed meanwhile and holds only until that register is free.
// ----------------------------------------------------------------------------
module k_way_merge_min_heap
  import kwm_pkg::*;
#(
  parameter int unsigned MAX_STREAMS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic REG_NUM_STREAMS = 1'b0;

  logic [4:0] num_streams_r;
  cmd_t       cmd;
  sts_t       sts;

  assign cfg_pready = 1'b1;

  // register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_streams_r <= 5'd1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 cfg_paddr[2] == REG_NUM_STREAMS) begin
      num_streams_r <= cfg_pwdata[4:0];
    end
  end

  // register read
  assign cfg_prdata = (cfg_paddr[2] == REG_NUM_STREAMS) ? {27'd0, num_streams_r} : 32'd0;

  kwm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  kwm_dp #(
    .MAX_STREAMS (MAX_STREAMS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_data     (in_data),
    .num_streams (num_streams_r),
    .out_ready   (out_ready),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_data    (out_data)
  );

endmodule
